@@ rtl/core/b64c_pkg.sv @@
package b64c_pkg;

  localparam int unsigned MaxResults = 4;

  // Character classes seen while decoding, beyond the 64 alphabet values.
  localparam logic [6:0] CodePad = 7'd64;
  localparam logic [6:0] CodeBad = 7'd65;

  localparam logic [7:0] PadChar = 8'h3D;

  typedef struct packed {
    logic [1:0] phase;
    logic [5:0] carry;
  } state_t;

  typedef struct packed {
    logic [2:0]                 count;
    logic [MaxResults-1:0][7:0] bytes;
  } burst_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  function automatic logic [6:0] char_value(input logic [7:0] c);
    logic [6:0] v;
    if (c inside {[8'h41:8'h5A]}) begin
      v = 7'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      v = 7'd62;
    end else if (c == 8'h2F) begin
      v = 7'd63;
    end else if (c == PadChar) begin
      v = CodePad;
    end else begin
      v = CodeBad;
    end
    return v;
  endfunction

endpackage

@@ rtl/core/b64c_in_if.sv @@
interface b64c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

@@ rtl/core/b64c_out_if.sv @@
interface b64c_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink (input valid, out_byte, last_of_run, output ready);
endinterface

@@ rtl/core/b64c_step.sv @@
module b64c_step (
  input  b64c_pkg::state_t state_i,
  input  logic             decode_mode_i,
  input  logic [7:0]       data_byte_i,
  input  logic             byte_present_i,
  input  logic             end_of_message_i,
  output b64c_pkg::state_t state_o,
  output b64c_pkg::burst_t burst_o
);

  logic [1:0]  phase;
  logic [5:0]  carry;
  logic [2:0]  n;
  logic [b64c_pkg::MaxResults-1:0][7:0] bytes;
  logic [11:0] enc_acc;
  logic [11:0] dec_acc;
  logic [6:0]  code;

  always_comb begin
    phase   = state_i.phase;
    carry   = state_i.carry;
    n       = 3'd0;
    bytes   = '0;
    enc_acc = '0;
    dec_acc = '0;
    code    = b64c_pkg::char_value(data_byte_i);

    if (byte_present_i && !decode_mode_i) begin
      // A group left in the fourth phase by a mode change starts over.
      if (phase == 2'd3) begin
        phase = 2'd0;
        carry = '0;
      end
      enc_acc = {carry[3:0], data_byte_i};
      case (phase)
        2'd0: begin
          bytes[n[1:0]] = b64c_pkg::sextet_char(enc_acc[7:2]);
          n     = n + 3'd1;
          carry = {4'b0, enc_acc[1:0]};
          phase = 2'd1;
        end
        2'd1: begin
          bytes[n[1:0]] = b64c_pkg::sextet_char(enc_acc[9:4]);
          n     = n + 3'd1;
          carry = {2'b0, enc_acc[3:0]};
          phase = 2'd2;
        end
        default: begin
          bytes[n[1:0]] = b64c_pkg::sextet_char(enc_acc[11:6]);
          n = n + 3'd1;
          bytes[n[1:0]] = b64c_pkg::sextet_char(enc_acc[5:0]);
          n     = n + 3'd1;
          carry = '0;
          phase = 2'd0;
        end
      endcase
    end else if (byte_present_i && decode_mode_i) begin
      dec_acc = {carry, code[5:0]};
      if (code == b64c_pkg::CodePad) begin
        phase = 2'd0;
        carry = '0;
      end else if (code != b64c_pkg::CodeBad) begin
        case (phase)
          2'd0: begin
            carry = code[5:0];
            phase = 2'd1;
          end
          2'd1: begin
            bytes[n[1:0]] = dec_acc[11:4];
            n     = n + 3'd1;
            carry = {2'b0, dec_acc[3:0]};
            phase = 2'd2;
          end
          2'd2: begin
            bytes[n[1:0]] = dec_acc[9:2];
            n     = n + 3'd1;
            carry = {4'b0, dec_acc[1:0]};
            phase = 2'd3;
          end
          default: begin
            bytes[n[1:0]] = dec_acc[7:0];
            n     = n + 3'd1;
            carry = '0;
            phase = 2'd0;
          end
        endcase
      end
    end

    if (end_of_message_i) begin
      if (!decode_mode_i && phase == 2'd2) begin
        bytes[n[1:0]] = b64c_pkg::sextet_char({carry[3:0], 2'b00});
        n = n + 3'd1;
        bytes[n[1:0]] = b64c_pkg::PadChar;
        n = n + 3'd1;
      end else if (!decode_mode_i && phase == 2'd1) begin
        bytes[n[1:0]] = b64c_pkg::sextet_char({carry[1:0], 4'b0000});
        n = n + 3'd1;
        bytes[n[1:0]] = b64c_pkg::PadChar;
        n = n + 3'd1;
        bytes[n[1:0]] = b64c_pkg::PadChar;
        n = n + 3'd1;
      end else if (decode_mode_i && phase == 2'd1) begin
        bytes[n[1:0]] = {carry, 2'b00};
        n = n + 3'd1;
      end
      phase = 2'd0;
      carry = '0;
    end

    state_o.phase = phase;
    state_o.carry = carry;
    burst_o.count = n;
    burst_o.bytes = bytes;
  end

endmodule

@@ rtl/core/base64_stream_codec_core.sv @@
// Channel  Dir  Payload                                       Transfer
// in_i     in   data_byte, byte_present, end_of_message       valid & ready
// out_o    out  out_byte, last_of_run                         valid & ready
// cfg      in   decode_mode_i                                 decode_mode_we_i
//
// An item is processed in the cycle it is taken; its zero to four results
// are held in a burst register and leave one per cycle while the output is
// ready: one or two for a byte when encoding, up to four when a flush comes
// with it.
// The next item is taken in the same cycle as the last result of a burst.
// Reset clears the mode, the group state and the burst state.
// A stalled output holds its result, and input waits until the last result
// of the pending burst is taken.
module base64_stream_codec_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             decode_mode_we_i,
  input  logic             decode_mode_i,
  b64c_in_if.sink          in_i,
  b64c_out_if.source       out_o
);

  logic                  decode_mode_q;
  b64c_pkg::state_t      state_q, state_d;
  b64c_pkg::burst_t      step_burst;
  logic                  busy_q;
  logic [2:0]            cnt_q;
  logic [1:0]            idx_q;
  logic [b64c_pkg::MaxResults-1:0][7:0] bytes_q;
  logic                  last_res;
  logic                  in_xfer;
  logic                  out_xfer;

  b64c_step u_step (
    .state_i         (state_q),
    .decode_mode_i   (decode_mode_q),
    .data_byte_i     (in_i.data_byte),
    .byte_present_i  (in_i.byte_present),
    .end_of_message_i(in_i.end_of_message),
    .state_o         (state_d),
    .burst_o         (step_burst)
  );

  assign last_res = ({1'b0, idx_q} == cnt_q - 3'd1);
  assign out_xfer = out_o.valid && out_o.ready;
  assign in_i.ready = !busy_q || (out_o.ready && last_res);
  assign in_xfer = in_i.valid && in_i.ready;

  assign out_o.valid       = busy_q;
  assign out_o.out_byte    = bytes_q[idx_q];
  assign out_o.last_of_run = last_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decode_mode_q <= 1'b0;
    end else if (decode_mode_we_i) begin
      decode_mode_q <= decode_mode_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
      busy_q  <= (step_burst.count != 3'd0);
      cnt_q   <= step_burst.count;
      idx_q   <= '0;
    end else if (out_xfer) begin
      if (last_res) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      bytes_q <= step_burst.bytes;
    end
  end

endmodule

@@ rtl/core/b64c_checker.sv @@
module b64c_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);

  // A result that is not taken stays offered unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // A burst continues until its last result has been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i)
    else $error("burst ended before its last result");

  // Input is only held off while results are pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result pending");

  // A new item is taken only when no earlier result would be left behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !out_valid_i || (out_ready_i && out_last_i))
    else $error("item taken while a burst is still pending");

endmodule

bind base64_stream_codec_core b64c_checker u_b64c_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_byte_i (out_o.out_byte),
  .out_last_i (out_o.last_of_run)
);
